// File: hw/rtl/btcf_pkg.sv
package btcf_pkg;

  // Neighborhood sums: nine 16-bit counts, and nine 8-bit counts.
  localparam int unsigned SUM_W = 20;
  localparam int unsigned H_W   = 12;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [1:0] OP_RADIAL = 2'd0;
  localparam logic [1:0] OP_POINT  = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SLICE     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CELL      = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CELL      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SURROUND  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SENSOR    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_MIN   = 4'd7;

  // Offset codes for a neighbor row or column.
  localparam logic [1:0] D_MINUS = 2'd0;
  localparam logic [1:0] D_ZERO  = 2'd1;
  localparam logic [1:0] D_PLUS  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_HIT_WR,
    ST_ROW,
    ST_ROW_CHK,
    ST_NB,
    ST_NB_END,
    ST_CHK,
    ST_SENS,
    ST_SENS_END,
    ST_FINAL,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic accept;
    logic hit_rd;
    logic hit_wr;
    logic row_next;
    logic cell_next;
    logic nb_step;
    logic sens_step;
    logic set_pass;
    logic load_result;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       item_ok;
    logic       total_ok;
    logic       slice_ok;
    logic       chk_a;
    logic       chk_b;
    logic       j_last;
    logic       k_last;
    logic       p_last;
    logic       r_last;
    logic       clr_last;
    logic       out_busy;
  } status_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Step index of the 3x3 walk to {row code, column code}.
  function automatic logic [3:0] nb_code(input logic [3:0] j);
    logic [3:0] c;
    unique case (j)
      4'd0:    c = {D_MINUS, D_MINUS};
      4'd1:    c = {D_MINUS, D_ZERO};
      4'd2:    c = {D_MINUS, D_PLUS};
      4'd3:    c = {D_ZERO, D_MINUS};
      4'd4:    c = {D_ZERO, D_ZERO};
      4'd5:    c = {D_ZERO, D_PLUS};
      4'd6:    c = {D_PLUS, D_MINUS};
      4'd7:    c = {D_PLUS, D_ZERO};
      4'd8:    c = {D_PLUS, D_PLUS};
      default: c = {D_ZERO, D_ZERO};
    endcase
    nb_code = c;
  endfunction

endpackage

// File: hw/rtl/btcf_if.sv
interface btcf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [6:0] r_bin;
  logic [6:0] phi_bin;
  logic [5:0] sensor_id;

  modport source (output valid, op, r_bin, phi_bin, sensor_id, input ready);
  modport sink   (input valid, op, r_bin, phi_bin, sensor_id, output ready);
endinterface

interface btcf_out_if;
  logic        valid;
  logic        ready;
  logic        event_pass;
  logic [15:0] total_points;
  logic [15:0] dropped_points;

  modport source (output valid, event_pass, total_points, dropped_points, input ready);
  modport sink   (input valid, event_pass, total_points, dropped_points, output ready);
endinterface

// File: hw/rtl/btcf_dp.sv
module btcf_dp #(
  parameter int unsigned R_BINS    = 36,
  parameter int unsigned PHI_BINS  = 36,
  parameter int unsigned SENSORS   = 42,
  parameter int unsigned WIDE_CELL = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [1:0]                           in_op_i,
  input  logic [6:0]                           in_r_i,
  input  logic [6:0]                           in_phi_i,
  input  logic [5:0]                           in_sensor_i,
  input  logic                                 cfg_we_i,
  input  logic [btcf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [btcf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  btcf_pkg::cmd_t                       cmd_i,
  output btcf_pkg::status_t                    status_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 out_pass_o,
  output logic [15:0]                          out_total_o,
  output logic [15:0]                          out_drop_o
);

  localparam int unsigned NCELLS = R_BINS * PHI_BINS;
  localparam int unsigned CW     = $clog2(NCELLS);
  localparam int unsigned RW     = $clog2(R_BINS);
  localparam int unsigned PW     = $clog2(PHI_BINS);
  localparam int unsigned SW     = (SENSORS > 1) ? $clog2(SENSORS) : 1;
  localparam int unsigned NSW    = $clog2(SENSORS + 1);
  localparam int unsigned NJ     = (WIDE_CELL != 0) ? 9 : 1;
  localparam int unsigned SDEPTH = NCELLS << SW;
  localparam int unsigned SUM_W  = btcf_pkg::SUM_W;
  localparam int unsigned H_W    = btcf_pkg::H_W;

  // Configuration
  logic [15:0] min_total_q, max_total_q, min_slice_q, min_cell_q, max_cell_q;
  logic [16:0] max_surround_q, overlap_q;
  logic [7:0]  max_sensor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_total_q    <= 16'd20;
      max_total_q    <= 16'd5000;
      min_slice_q    <= 16'd18;
      min_cell_q     <= 16'd18;
      max_cell_q     <= 16'd100;
      max_surround_q <= 17'h1FFFF;
      max_sensor_q   <= 8'd25;
      overlap_q      <= 17'h1FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btcf_pkg::REG_MIN_TOTAL:    min_total_q    <= cfg_wdata_i[15:0];
        btcf_pkg::REG_MAX_TOTAL:    max_total_q    <= cfg_wdata_i[15:0];
        btcf_pkg::REG_MIN_SLICE:    min_slice_q    <= cfg_wdata_i[15:0];
        btcf_pkg::REG_MIN_CELL:     min_cell_q     <= cfg_wdata_i[15:0];
        btcf_pkg::REG_MAX_CELL:     max_cell_q     <= cfg_wdata_i[15:0];
        btcf_pkg::REG_MAX_SURROUND: max_surround_q <= cfg_wdata_i;
        btcf_pkg::REG_MAX_SENSOR:   max_sensor_q   <= cfg_wdata_i[7:0];
        btcf_pkg::REG_OVERLAP_MIN:  overlap_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latched transaction
  logic [1:0] op_q;
  logic [6:0] r_q, p_q;
  logic [5:0] s_q;
  logic       ok_q;
  logic       r_ok, p_ok, s_ok, item_ok;

  assign r_ok    = in_r_i < 7'(R_BINS);
  assign p_ok    = in_phi_i < 7'(PHI_BINS);
  assign s_ok    = {1'b0, in_sensor_i} < 7'(SENSORS);
  assign item_ok = (in_op_i == btcf_pkg::OP_RADIAL) ? r_ok : (r_ok && p_ok && s_ok);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= in_op_i;
      r_q  <= in_r_i;
      p_q  <= in_phi_i;
      s_q  <= in_sensor_i;
      ok_q <= item_ok;
    end
  end

  logic [CW-1:0]    item_cell;
  logic [CW+SW-1:0] item_saddr;
  assign item_cell  = CW'(r_q[RW-1:0]) * CW'(PHI_BINS) + CW'(p_q[PW-1:0]);
  assign item_saddr = {item_cell, s_q[SW-1:0]};

  // Scan position
  logic [RW-1:0] sr_q;
  logic [PW-1:0] sp_q;
  logic [3:0]    j_q;
  logic [SW-1:0] k_q;
  logic          pass_q;
  logic          j_last, k_last, p_last, r_last;

  assign j_last = j_q == 4'(NJ - 1);
  assign k_last = k_q == SW'(SENSORS - 1);
  assign p_last = sp_q == PW'(PHI_BINS - 1);
  assign r_last = sr_q == RW'(R_BINS - 1);

  logic [3:0]    nb;
  logic [1:0]    dr, dc;
  logic [RW-1:0] row;
  logic [PW-1:0] col;
  logic          row_ok;
  logic [CW-1:0] nb_cell;

  assign nb = (WIDE_CELL != 0) ? btcf_pkg::nb_code(j_q)
                               : {btcf_pkg::D_ZERO, btcf_pkg::D_ZERO};
  assign dr = nb[3:2];
  assign dc = nb[1:0];

  always_comb begin
    priority if (dr == btcf_pkg::D_MINUS) begin
      row    = sr_q - RW'(1);
      row_ok = sr_q != '0;
    end else if (dr == btcf_pkg::D_PLUS) begin
      row    = sr_q + RW'(1);
      row_ok = !r_last;
    end else begin
      row    = sr_q;
      row_ok = 1'b1;
    end
    // phi wraps around
    priority if (dc == btcf_pkg::D_MINUS) begin
      col = (sp_q == '0) ? PW'(PHI_BINS - 1) : sp_q - PW'(1);
    end else if (dc == btcf_pkg::D_PLUS) begin
      col = p_last ? '0 : sp_q + PW'(1);
    end else begin
      col = sp_q;
    end
  end

  assign nb_cell = CW'(row) * CW'(PHI_BINS) + CW'(col);

  // Clear sweep counter
  logic [CW+SW-1:0] clr_q;
  logic [CW-1:0]    clr_cell;
  logic             clr_last;
  assign clr_cell = clr_q[CW+SW-1:SW];
  assign clr_last = (clr_cell == CW'(NCELLS - 1)) && (clr_q[SW-1:0] == '1);

  // Histogram memories
  logic [15:0] slice_mem [R_BINS];
  logic [15:0] cell_mem  [NCELLS];
  logic [15:0] left_mem  [NCELLS];
  logic [15:0] right_mem [NCELLS];
  logic [7:0]  sens_mem  [SDEPTH];

  logic [15:0] slice_rd_q, cell_rd_q, left_rd_q, right_rd_q;
  logic [7:0]  sens_rd_q;

  logic [RW-1:0]    slice_ra, slice_wa;
  logic [CW-1:0]    cell_ra, cell_wa;
  logic [CW+SW-1:0] sens_ra, sens_wa;
  logic             point_wr, slice_we, cell_we, left_we, right_we;
  logic [15:0]      slice_wd, cell_wd, left_wd, right_wd;
  logic [7:0]       sens_wd;

  assign slice_ra = cmd_i.hit_rd ? r_q[RW-1:0] : sr_q;
  assign cell_ra  = cmd_i.hit_rd ? item_cell : nb_cell;
  assign sens_ra  = cmd_i.hit_rd ? item_saddr : {nb_cell, k_q};

  assign slice_wa = cmd_i.clr_step ? clr_cell[RW-1:0] : r_q[RW-1:0];
  assign cell_wa  = cmd_i.clr_step ? clr_cell : item_cell;
  assign sens_wa  = cmd_i.clr_step ? clr_q : item_saddr;

  assign point_wr = cmd_i.hit_wr && (op_q == btcf_pkg::OP_POINT);
  assign slice_we = (cmd_i.hit_wr && (op_q == btcf_pkg::OP_RADIAL)) ||
                    (cmd_i.clr_step && (clr_cell < CW'(R_BINS)));
  assign cell_we  = point_wr || cmd_i.clr_step;
  assign left_we  = (point_wr && !s_q[0]) || cmd_i.clr_step;
  assign right_we = (point_wr && s_q[0]) || cmd_i.clr_step;

  assign slice_wd = cmd_i.clr_step ? '0 : btcf_pkg::sat_inc16(slice_rd_q);
  assign cell_wd  = cmd_i.clr_step ? '0 : btcf_pkg::sat_inc16(cell_rd_q);
  assign left_wd  = cmd_i.clr_step ? '0 : btcf_pkg::sat_inc16(left_rd_q);
  assign right_wd = cmd_i.clr_step ? '0 : btcf_pkg::sat_inc16(right_rd_q);
  assign sens_wd  = cmd_i.clr_step ? '0 : btcf_pkg::sat_inc8(sens_rd_q);

  always_ff @(posedge clk_i) begin
    slice_rd_q <= slice_mem[slice_ra];
    if (slice_we) slice_mem[slice_wa] <= slice_wd;
  end

  always_ff @(posedge clk_i) begin
    cell_rd_q  <= cell_mem[cell_ra];
    left_rd_q  <= left_mem[cell_ra];
    right_rd_q <= right_mem[cell_ra];
    if (cell_we)  cell_mem[cell_wa]  <= cell_wd;
    if (left_we)  left_mem[cell_wa]  <= left_wd;
    if (right_we) right_mem[cell_wa] <= right_wd;
  end

  always_ff @(posedge clk_i) begin
    sens_rd_q <= sens_mem[sens_ra];
    if (cell_we) sens_mem[sens_wa] <= sens_wd;
  end

  // Read tags, aligned with the registered read data
  logic rd_v_q, rd_sens_q, rd_first_q, rd_last_q, rd_rowok_q, rd_centre_q, rd_kfirst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.nb_step || cmd_i.sens_step;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sens_q   <= cmd_i.sens_step;
    rd_first_q  <= j_q == '0;
    rd_last_q   <= j_last;
    rd_rowok_q  <= row_ok;
    rd_centre_q <= (dr == btcf_pkg::D_ZERO) && (dc == btcf_pkg::D_ZERO);
    rd_kfirst_q <= k_q == '0;
  end

  // Neighborhood accumulators
  logic [SUM_W-1:0] cs_q, ls_q, rs_q;
  logic [15:0]      centre_q;
  logic [H_W-1:0]   h_q, h_next, maxs_q;
  logic [NSW-1:0]   nsens_q;

  assign h_next = (rd_first_q ? '0 : h_q) + (rd_rowok_q ? H_W'(sens_rd_q) : '0);

  always_ff @(posedge clk_i) begin
    if (rd_v_q && !rd_sens_q) begin
      cs_q <= (rd_first_q ? '0 : cs_q) + (rd_rowok_q ? SUM_W'(cell_rd_q) : '0);
      ls_q <= (rd_first_q ? '0 : ls_q) + (rd_rowok_q ? SUM_W'(left_rd_q) : '0);
      rs_q <= (rd_first_q ? '0 : rs_q) + (rd_rowok_q ? SUM_W'(right_rd_q) : '0);
      if (rd_centre_q) centre_q <= cell_rd_q;
    end
    if (rd_v_q && rd_sens_q) begin
      h_q <= h_next;
      // fold the finished sensor sum into max and occupancy
      if (rd_last_q) begin
        if (rd_kfirst_q) begin
          maxs_q  <= h_next;
          nsens_q <= NSW'(h_next != '0);
        end else begin
          if (h_next > maxs_q) maxs_q <= h_next;
          if (h_next != '0) nsens_q <= nsens_q + NSW'(1);
        end
      end
    end
  end

  logic [SUM_W-1:0] excess;
  logic             surr_ok, chk_a, chk_b;

  assign excess  = cs_q - SUM_W'(centre_q);
  assign surr_ok = max_surround_q[16] ? (excess <= SUM_W'(centre_q))
                                      : (excess <= SUM_W'(max_surround_q[15:0]));
  assign chk_a   = (centre_q >= min_cell_q) && (centre_q <= max_cell_q) && surr_ok;
  assign chk_b   = (maxs_q <= H_W'(max_sensor_q)) && (16'(nsens_q) >= min_cell_q) &&
                   (overlap_q[16] || ((ls_q > SUM_W'(overlap_q[15:0])) &&
                                      (rs_q > SUM_W'(overlap_q[15:0]))));

  // Control counters and totals
  logic [15:0] point_q, drop_q;
  logic        out_valid_q, out_pass_q;
  logic [15:0] out_total_q, out_drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= '0;
      sp_q        <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pass_q      <= 1'b0;
      clr_q       <= '0;
      point_q     <= '0;
      drop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        sr_q   <= '0;
        sp_q   <= '0;
        pass_q <= 1'b0;
        if ((in_op_i == btcf_pkg::OP_RADIAL || in_op_i == btcf_pkg::OP_POINT) && !item_ok) begin
          drop_q <= btcf_pkg::sat_inc16(drop_q);
        end
      end
      if (point_wr) point_q <= btcf_pkg::sat_inc16(point_q);
      if (cmd_i.row_next) begin
        sr_q <= sr_q + RW'(1);
        sp_q <= '0;
      end
      if (cmd_i.cell_next) begin
        if (p_last) begin
          sp_q <= '0;
          sr_q <= sr_q + RW'(1);
        end else begin
          sp_q <= sp_q + PW'(1);
        end
      end
      if (cmd_i.nb_step) j_q <= j_last ? '0 : j_q + 4'd1;
      if (cmd_i.sens_step) begin
        if (j_last) begin
          j_q <= '0;
          k_q <= k_last ? '0 : k_q + SW'(1);
        end else begin
          j_q <= j_q + 4'd1;
        end
      end
      if (cmd_i.set_pass) pass_q <= 1'b1;
      if (cmd_i.clr_step) clr_q <= clr_last ? '0 : clr_q + (CW+SW)'(1);
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
        point_q     <= '0;
        drop_q      <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      out_pass_q  <= pass_q;
      out_total_q <= point_q;
      out_drop_q  <= drop_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pass_o  = out_pass_q;
  assign out_total_o = out_total_q;
  assign out_drop_o  = out_drop_q;

  always_comb begin
    status_o          = '0;
    status_o.op       = op_q;
    status_o.item_ok  = ok_q;
    status_o.total_ok = (point_q >= min_total_q) && (point_q <= max_total_q);
    status_o.slice_ok = slice_rd_q >= min_slice_q;
    status_o.chk_a    = chk_a;
    status_o.chk_b    = chk_b;
    status_o.j_last   = j_last;
    status_o.k_last   = k_last;
    status_o.p_last   = p_last;
    status_o.r_last   = r_last;
    status_o.clr_last = clr_last;
    status_o.out_busy = out_valid_q;
  end

endmodule

// File: hw/rtl/btcf_ctrl.sv
module btcf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  btcf_pkg::status_t status_i,
  output btcf_pkg::cmd_t    cmd_o
);

  btcf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btcf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      btcf_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = btcf_pkg::ST_IDLE;
      end
      btcf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = btcf_pkg::ST_DISPATCH;
        end
      end
      btcf_pkg::ST_DISPATCH: begin
        unique case (status_i.op)
          btcf_pkg::OP_RADIAL, btcf_pkg::OP_POINT: begin
            if (status_i.item_ok) begin
              cmd_o.hit_rd = 1'b1;
              state_d      = btcf_pkg::ST_HIT_WR;
            end else begin
              state_d = btcf_pkg::ST_IDLE;
            end
          end
          btcf_pkg::OP_EVAL: begin
            state_d = status_i.total_ok ? btcf_pkg::ST_ROW : btcf_pkg::ST_RESULT;
          end
          default: state_d = btcf_pkg::ST_IDLE;
        endcase
      end
      btcf_pkg::ST_HIT_WR: begin
        cmd_o.hit_wr = 1'b1;
        state_d      = btcf_pkg::ST_IDLE;
      end
      btcf_pkg::ST_ROW: begin
        state_d = btcf_pkg::ST_ROW_CHK;
      end
      btcf_pkg::ST_ROW_CHK: begin
        // skip the whole row when its slice is too thin
        if (status_i.slice_ok) begin
          state_d = btcf_pkg::ST_NB;
        end else if (status_i.r_last) begin
          state_d = btcf_pkg::ST_RESULT;
        end else begin
          cmd_o.row_next = 1'b1;
          state_d        = btcf_pkg::ST_ROW;
        end
      end
      btcf_pkg::ST_NB: begin
        cmd_o.nb_step = 1'b1;
        if (status_i.j_last) state_d = btcf_pkg::ST_NB_END;
      end
      btcf_pkg::ST_NB_END: begin
        state_d = btcf_pkg::ST_CHK;
      end
      btcf_pkg::ST_CHK: begin
        if (status_i.chk_a) begin
          state_d = btcf_pkg::ST_SENS;
        end else if (status_i.p_last && status_i.r_last) begin
          state_d = btcf_pkg::ST_RESULT;
        end else begin
          cmd_o.cell_next = 1'b1;
          state_d = status_i.p_last ? btcf_pkg::ST_ROW : btcf_pkg::ST_NB;
        end
      end
      btcf_pkg::ST_SENS: begin
        cmd_o.sens_step = 1'b1;
        if (status_i.j_last && status_i.k_last) state_d = btcf_pkg::ST_SENS_END;
      end
      btcf_pkg::ST_SENS_END: begin
        state_d = btcf_pkg::ST_FINAL;
      end
      btcf_pkg::ST_FINAL: begin
        // one passing cell settles the event
        if (status_i.chk_b) begin
          cmd_o.set_pass = 1'b1;
          state_d        = btcf_pkg::ST_RESULT;
        end else if (status_i.p_last && status_i.r_last) begin
          state_d = btcf_pkg::ST_RESULT;
        end else begin
          cmd_o.cell_next = 1'b1;
          state_d = status_i.p_last ? btcf_pkg::ST_ROW : btcf_pkg::ST_NB;
        end
      end
      btcf_pkg::ST_RESULT: begin
        // hold until the previous result has been taken
        if (!status_i.out_busy) begin
          cmd_o.load_result = 1'b1;
          state_d           = btcf_pkg::ST_CLEAR;
        end
      end
      default: state_d = btcf_pkg::ST_CLEAR;
    endcase
  end

endmodule

// File: hw/rtl/binned_track_cluster_filter_top.sv
// Hit transaction (radial hit or space point): one read and one write-back of the histogram
// memories; a dropped item or an unused op code writes no histogram memory.
// End of event: if the point total is within its bounds, each r slice is checked, and each
// scanned cell that passes its center and surround cuts has its sensor sums checked; the
// scan stops at the first passing cell. Then a clear sweep of every histogram memory.
// Reset: config registers take their reset values; the same clear sweep runs first.
module binned_track_cluster_filter_top #(
  parameter int unsigned R_BINS    = 36,
  parameter int unsigned PHI_BINS  = 36,
  parameter int unsigned SENSORS   = 42,
  parameter int unsigned WIDE_CELL = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  btcf_in_if.sink                         in_i,
  btcf_out_if.source                      out_o,
  input  logic                            cfg_we_i,
  input  logic [btcf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [btcf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  btcf_pkg::cmd_t    cmd;
  btcf_pkg::status_t status;

  btcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  btcf_dp #(
    .R_BINS    (R_BINS),
    .PHI_BINS  (PHI_BINS),
    .SENSORS   (SENSORS),
    .WIDE_CELL (WIDE_CELL)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_op_i     (in_i.op),
    .in_r_i      (in_i.r_bin),
    .in_phi_i    (in_i.phi_bin),
    .in_sensor_i (in_i.sensor_id),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_pass_o  (out_o.event_pass),
    .out_total_o (out_o.total_points),
    .out_drop_o  (out_o.dropped_points)
  );

endmodule

// File: hw/rtl/btcf_checker.sv
module btcf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_pass_i,
  input logic [15:0] out_total_i,
  input logic [15:0] out_drop_i
);

  // result transaction holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_pass_i) && $stable(out_total_i) && $stable(out_drop_i))
    else $error("result payload changed while stalled");

  // end of event blocks further input
  a_eval_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == btcf_pkg::OP_EVAL) |=> !in_ready_i)
    else $error("input taken right after end of event");

  // a new result starts the clear sweep
  a_clear_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("input ready while stores are cleared");

endmodule

bind binned_track_cluster_filter_top btcf_checker u_btcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_pass_i  (out_o.event_pass),
  .out_total_i (out_o.total_points),
  .out_drop_i  (out_o.dropped_points)
);
